[design/etot_pkg.sv]
// Package: widths, microcode encodings and the control ROM of the totient sequencer.
package etot_pkg;

   localparam int N_BITS = 32;
   localparam int CNT_W  = $clog2(N_BITS + 1);
   localparam int PC_W   = 5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SHIFT,
      OP_HALVE,
      OP_DIV_NI,
      OP_DIV_RI,
      OP_DIV_RN,
      OP_TAKE,
      OP_SUB_Q,
      OP_INC,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_N_ZERO,
      C_N_ODD,
      C_N1_ZERO,
      C_I_GT_Q,
      C_R_NZ,
      C_R_ZERO,
      C_N_LE1
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } uop_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Program steps
   localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
   localparam logic [PC_W-1:0] PC_SHIFT = PC_W'(3);
   localparam logic [PC_W-1:0] PC_DIVNI = PC_W'(5);
   localparam logic [PC_W-1:0] PC_TAKE  = PC_W'(8);
   localparam logic [PC_W-1:0] PC_INC   = PC_W'(13);
   localparam logic [PC_W-1:0] PC_FINAL = PC_W'(14);
   localparam logic [PC_W-1:0] PC_OUT   = PC_W'(17);

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{op: OP_NONE, cond: C_ALWAYS, target: PC_LOAD};
      unique case (pc)
         5'd0:    u = '{op: OP_LOAD,   cond: C_NEXT,    target: PC_LOAD};
         5'd1:    u = '{op: OP_NONE,   cond: C_N_ZERO,  target: PC_OUT};
         5'd2:    u = '{op: OP_NONE,   cond: C_N_ODD,   target: PC_DIVNI};
         5'd3:    u = '{op: OP_SHIFT,  cond: C_N1_ZERO, target: PC_SHIFT};
         5'd4:    u = '{op: OP_HALVE,  cond: C_NEXT,    target: PC_LOAD};
         5'd5:    u = '{op: OP_DIV_NI, cond: C_NEXT,    target: PC_LOAD};
         5'd6:    u = '{op: OP_NONE,   cond: C_I_GT_Q,  target: PC_FINAL};
         5'd7:    u = '{op: OP_NONE,   cond: C_R_NZ,    target: PC_INC};
         5'd8:    u = '{op: OP_TAKE,   cond: C_NEXT,    target: PC_LOAD};
         5'd9:    u = '{op: OP_DIV_NI, cond: C_NEXT,    target: PC_LOAD};
         5'd10:   u = '{op: OP_NONE,   cond: C_R_ZERO,  target: PC_TAKE};
         5'd11:   u = '{op: OP_DIV_RI, cond: C_NEXT,    target: PC_LOAD};
         5'd12:   u = '{op: OP_SUB_Q,  cond: C_NEXT,    target: PC_LOAD};
         5'd13:   u = '{op: OP_INC,    cond: C_ALWAYS,  target: PC_DIVNI};
         5'd14:   u = '{op: OP_NONE,   cond: C_N_LE1,   target: PC_OUT};
         5'd15:   u = '{op: OP_DIV_RN, cond: C_NEXT,    target: PC_LOAD};
         5'd16:   u = '{op: OP_SUB_Q,  cond: C_NEXT,    target: PC_LOAD};
         5'd17:   u = '{op: OP_OUT,    cond: C_ALWAYS,  target: PC_LOAD};
         default: u = '{op: OP_NONE,   cond: C_ALWAYS,  target: PC_LOAD};
      endcase
      return u;
   endfunction

endpackage

[design/etot_req_if.sv]
// Request channel interface: valid/ready handshake carrying n_value.
interface etot_req_if import etot_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [N_BITS-1:0] n_value;

   modport source (output valid, output n_value, input ready);
   modport sink   (input valid, input n_value, output ready);
endinterface

[design/etot_rsp_if.sv]
// Response channel interface: valid/ready handshake carrying phi_value.
interface etot_rsp_if import etot_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [N_BITS-1:0] phi_value;

   modport source (output valid, output phi_value, input ready);
   modport sink   (input valid, input phi_value, output ready);
endinterface

[design/euler_totient.sv]
// Euler totient by trial division: microcoded sequencer over a shared bit-serial divider.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    n_value   [31:0]
//   rsp_ch   out  valid/ready    phi_value [31:0]
//
// One item at a time. Each trial divisor costs one n/i divide step through the shared
// divider plus three further steps (quotient compare, remainder test, increment).
// The next request is taken while a finished result waits in the output register.
// Synchronous reset returns the sequencer to its load step and empties the output.
module euler_totient import etot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   etot_req_if.sink     req_ch,
   etot_rsp_if.source   rsp_ch
);

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [N_BITS-1:0] n_ff, n_in;
   logic [N_BITS-1:0] res_ff, res_in;
   logic [N_BITS-1:0] i_ff, i_in;
   logic              issued_ff, issued_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [N_BITS-1:0] rsp_phi_ff, rsp_phi_in;

   uop_type           uop;
   logic              is_div;
   logic              stall;
   logic              cond_true;
   logic              div_start;
   logic [N_BITS-1:0] div_dividend;
   logic [N_BITS-1:0] div_divisor;
   div_stat_type      div_stat;
   logic [N_BITS-1:0] div_quot;
   logic [N_BITS-1:0] div_rem;

   etot_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      uop    = ucode(pc_ff);
      is_div = (uop.op == OP_DIV_NI) || (uop.op == OP_DIV_RI) || (uop.op == OP_DIV_RN);

      unique case (uop.op)
         OP_DIV_RI: begin
            div_dividend = res_ff;
            div_divisor  = i_ff;
         end
         OP_DIV_RN: begin
            div_dividend = res_ff;
            div_divisor  = n_ff;
         end
         default: begin
            div_dividend = n_ff;
            div_divisor  = i_ff;
         end
      endcase
      div_start = is_div && !issued_ff;

      stall = ((uop.op == OP_LOAD) && !req_ch.valid) ||
              (is_div && !div_stat.done) ||
              ((uop.op == OP_OUT) && rsp_valid_ff && !rsp_ch.ready);

      unique case (uop.cond)
         C_NEXT:    cond_true = 1'b0;
         C_ALWAYS:  cond_true = 1'b1;
         C_N_ZERO:  cond_true = (n_ff == '0);
         C_N_ODD:   cond_true = n_ff[0];
         C_N1_ZERO: cond_true = !n_ff[1];   // bit 0 after this shift
         C_I_GT_Q:  cond_true = (i_ff > div_quot);
         C_R_NZ:    cond_true = (div_rem != '0);
         C_R_ZERO:  cond_true = (div_rem == '0);
         C_N_LE1:   cond_true = (n_ff <= N_BITS'(1));
         default:   cond_true = 1'b0;
      endcase

      pc_in        = pc_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      i_in         = i_ff;
      rsp_phi_in   = rsp_phi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (div_start) begin
         issued_in = 1'b1;
      end else if (div_stat.done) begin
         issued_in = 1'b0;
      end else begin
         issued_in = issued_ff;
      end

      if (!stall) begin
         pc_in = cond_true ? uop.target : pc_ff + PC_W'(1);
         unique case (uop.op)
            OP_LOAD: begin
               n_in   = req_ch.n_value;
               res_in = req_ch.n_value;
               i_in   = N_BITS'(3);
            end
            OP_SHIFT: n_in   = n_ff >> 1;
            OP_HALVE: res_in = res_ff - (res_ff >> 1);
            OP_TAKE:  n_in   = div_quot;
            OP_SUB_Q: res_in = res_ff - div_quot;
            OP_INC:   i_in   = i_ff + N_BITS'(2);
            OP_OUT: begin
               rsp_valid_in = 1'b1;
               rsp_phi_in   = res_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_LOAD;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      res_ff     <= res_in;
      i_ff       <= i_in;
      rsp_phi_ff <= rsp_phi_in;
   end

   assign req_ch.ready     = (uop.op == OP_LOAD);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.phi_value = rsp_phi_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> is_div)
      else $error("divider result arrived outside a divide step");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      ((uop.op == OP_OUT) && !stall) |=> (rsp_ch.valid && (pc_ff == PC_LOAD)))
      else $error("result not presented after output step");
`endif

endmodule

[design/etot_div.sv]
// Restoring divider, one quotient bit per cycle, quotient and remainder held after done.
module etot_div import etot_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] dividend,
   input  logic [N_BITS-1:0] divisor,
   output div_stat_type      stat,
   output logic [N_BITS-1:0] quot,
   output logic [N_BITS-1:0] rem
);

   logic [N_BITS-1:0] quot_ff, quot_in;
   logic [N_BITS-1:0] rem_ff, rem_in;
   logic [N_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [N_BITS:0]   trial;
   logic [N_BITS:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[N_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[N_BITS-2:0], fits};
         rem_in  = fits ? diff[N_BITS-1:0] : trial[N_BITS-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;
   assign rem       = rem_ff;

endmodule

[tb/sv/euler_totient_tb.sv]
// Testbench for euler_totient: directed and random totient requests checked against a local predictor.
`timescale 1ns / 1ps

module euler_totient_tb;
   import etot_pkg::*;

   logic clock;
   logic reset = 1'b1;

   etot_req_if req_ch ();
   etot_rsp_if rsp_ch ();

   euler_totient dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [N_BITS-1:0] phi_expected[$];
   bit                idle_on     = 1'b1;
   int                rsp_stall   = 0;
   int                error_count = 0;
   int                sent_count  = 0;
   int                phi_checked = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Trial-division totient, same loop bound test as the block (i <= n / i).
   function automatic logic [N_BITS-1:0] calc_phi(input logic [N_BITS-1:0] n_in);
      logic [N_BITS-1:0] rest;
      logic [N_BITS-1:0] phi;
      logic [N_BITS-1:0] div;
      if (n_in == '0)
         return '0;
      rest = n_in;
      phi  = n_in;
      if (!rest[0]) begin
         while (!rest[0])
            rest = rest >> 1;
         phi = phi - phi / 2;
      end
      for (div = N_BITS'(3); div <= rest / div; div += N_BITS'(2)) begin
         if (rest % div == 0) begin
            while (rest % div == 0)
               rest = rest / div;
            phi = phi - phi / div;
         end
      end
      if (rest > 1)
         phi = phi - phi / rest;
      return phi;
   endfunction

   task automatic report_mismatch(input string what, input logic [N_BITS-1:0] got,
                                  input logic [N_BITS-1:0] want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Drive one request and hold it until the transfer happens.
   task automatic send_n(input logic [N_BITS-1:0] n);
      int gap;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.n_value <= n;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      phi_expected.push_back(calc_phi(n));
      sent_count++;
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly cheap operands: small values, shifted 16-bit values, smooth products
   // and values with the low 12 bits clear, so the odd part stays below 2^20.
   function automatic logic [N_BITS-1:0] pick_n();
      logic [63:0] prod;
      logic [63:0] fac;
      int          kind;
      int          nfac;
      kind = $urandom_range(0, 9);
      if (kind <= 3)
         return $urandom_range(0, 4095);
      if (kind <= 5)
         return N_BITS'($urandom_range(1, 65535)) << $urandom_range(0, 16);
      if (kind <= 8) begin
         prod = 64'd1;
         nfac = $urandom_range(1, 12);
         repeat (nfac) begin
            fac = 64'($urandom_range(2, 251));
            if (prod * fac <= 64'hFFFF_FFFF)
               prod = prod * fac;
         end
         return prod[N_BITS-1:0];
      end
      return $urandom() & 32'hFFFF_F000;
   endfunction

   // Result side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_stall != 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
         rsp_stall    <= $urandom_range(1, 18) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (phi_expected.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_ch.phi_value, '0);
         end else begin
            logic [N_BITS-1:0] want;
            want = phi_expected.pop_front();
            if (rsp_ch.phi_value !== want)
               report_mismatch("phi_value", rsp_ch.phi_value, want);
         end
         phi_checked++;
      end
   end

   task automatic test_edge_values();
      send_n(32'd0);
      send_n(32'd1);
      send_n(32'd2);
      send_n(32'd3);
      send_n(32'd4);
      send_n(32'hFFFF_FFFF);
      send_n(32'h8000_0000);
      send_n(32'hAAAA_AAAA);
      send_n(32'h5555_5555);
      stop_sending();
   endtask

   task automatic test_primes();
      send_n(32'd97);
      send_n(32'd251);
      send_n(32'd65521);
      send_n(32'd16777213);
      stop_sending();
   endtask

   // Loop bound: divisor squared equal to, or just around, the remaining cofactor.
   task automatic test_loop_bound();
      send_n(32'd9);
      send_n(32'd49);
      send_n(32'd1042441);
      send_n(32'd1040399);
      send_n(32'd2084882);
      send_n(32'd3486784401);
      send_n(32'd1024 * 1023);
      stop_sending();
   endtask

   task automatic test_random(input int count);
      repeat (count)
         send_n(pick_n());
      stop_sending();
   endtask

   task automatic wait_drain();
      while (phi_expected.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.n_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_values();
      test_primes();
      test_loop_bound();
      test_random(60);
      idle_on = 1'b0;
      test_random(20);
      wait_drain();

      $display("Sent %0d totient requests: zero, one, all-ones, powers of two, primes,",
               sent_count);
      $display("prime squares and a random mix; %0d results checked", phi_checked);
      if (error_count == 0)
         $display("euler_totient_tb OK");
      else
         $display("euler_totient_tb NOT OK");
      $finish;
   end

   initial begin
      #(16_000_000);
      $display("Timeout with %0d results outstanding", phi_expected.size());
      $display("euler_totient_tb NOT OK");
      $finish;
   end

endmodule
